### rtl/rfwdl_pkg.sv
// Package for the ramped fractional-write delay line.
// Fixed widths, codes and saturation helpers shared by the rtl files.
// No dependencies.
package rfwdl_pkg;

  localparam int SAMPLE_W = 16;   // Q1.15 audio
  localparam int TARGET_W = 12;   // whole-sample target length
  localparam int FRAC_BITS = 12;  // Q.12 fractional length
  localparam int CELL_W = 18;     // store cell width
  localparam int STEPS_W = 16;    // ramp_steps register
  localparam int TDATA_IN_W = 32;

  localparam logic [STEPS_W-1:0] RAMP_STEPS_RST = 16'd4410;
  localparam int HALF_LSB = 2048;

  // action codes carried in tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_SET = 1'b1;

  // clamp a 19-bit sum to an 18-bit cell
  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [CELL_W:0] v);
    logic signed [CELL_W-1:0] r;
    if (v[CELL_W] != v[CELL_W-1]) begin
      r = v[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
    end else begin
      r = v[CELL_W-1:0];
    end
    return r;
  endfunction

  // clamp a cell to a Q1.15 sample
  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [CELL_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > $signed(CELL_W'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed(CELL_W'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/ramped_fractional_write_delay_line.sv
// Multi-channel delay line with a fractional write head and a plain read tap.
// Depends on rfwdl_pkg, rfwdl_store and rfwdl_div.
//
// A sample beat (tuser action = 0) runs through a sequencer that makes at most
// one access per step to a single-port store: erase the cell behind the read
// head, read-modify-write the near cell at read + floor(len), the same for
// the cell after it, then read the cell at the read head. The input is split
// as x - b and b, b = round(x * frac / 4096), and every add saturates to 18
// bits; the output saturates to 16 bits and leaves through an output
// register. The input is held off from a sample beat's acceptance until its
// result is loaded there, which waits for a free output slot. A set beat
// (action = 1) clamps the target to MAX_DELAY and starts a linear glide
// over ramp_steps samples; the step comes from a shared bit-serial divider,
// so a set beat that starts a glide holds the input off until the divider
// is done. One that repeats the current goal changes nothing, and with
// ramp_steps = 0 the length jumps to the target. After reset the store is
// swept to zero, all NUM_CHANNELS * MAX_DELAY cells (8192 by default), and
// s_tready stays low until the sweep is done. The configuration port is
// always ready.
module ramped_fractional_write_delay_line #(
  parameter int MAX_DELAY = 4096,
  parameter int NUM_CHANNELS = 2,
  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input beats
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rfwdl_pkg::TDATA_IN_W-1:0]     s_tdata,  // sample_in, target_length, zero pad
  input  logic [CHW:0]                         s_tuser,  // action, channel
  // result beats
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rfwdl_pkg::SAMPLE_W-1:0]       m_tdata,  // sample_out
  output logic [CHW-1:0]                       m_tuser,  // out_channel
  // ramp_steps register
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rfwdl_pkg::STEPS_W-1:0]        cfg_data
);
  import rfwdl_pkg::*;

  localparam int RW = $clog2(MAX_DELAY);         // read position
  localparam int GW = $clog2(MAX_DELAY + 1);     // whole length incl. MAX_DELAY
  localparam int LW = GW + FRAC_BITS;            // Q.12 length
  localparam int DEPTH = NUM_CHANNELS * MAX_DELAY;
  localparam int SAW = $clog2(DEPTH);
  localparam int TW = (GW > TARGET_W) ? GW : TARGET_W;
  localparam int PW = SAMPLE_W + FRAC_BITS + 1;  // product width

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERASE  = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_SPLIT  = 4'd3;
  localparam logic [3:0] S_NEAR   = 4'd4;
  localparam logic [3:0] S_FAR_RD = 4'd5;
  localparam logic [3:0] S_FAR    = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_SET    = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;

  logic [3:0] state;

  // latched beat
  logic [CHW-1:0]             ch_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [TARGET_W-1:0]        tgt_r;

  // working registers
  logic [LW-1:0]              len_r;
  logic signed [PW-1:0]       prod_r;
  logic signed [SAMPLE_W:0]   far_r;
  logic signed [SAMPLE_W:0]   near_r;
  logic [RW-1:0]              wp_r;
  logic [RW-1:0]              wp1_r;
  logic                       neg_r;
  logic [STEPS_W-1:0]         ramp_steps;

  // per-channel state
  logic [RW-1:0]              rp [NUM_CHANNELS];
  logic [LW-1:0]              cur_len [NUM_CHANNELS];
  logic [GW-1:0]              goal [NUM_CHANNELS];
  logic signed [LW:0]         ramp_inc [NUM_CHANNELS];
  logic [STEPS_W-1:0]         ramp_rem [NUM_CHANNELS];

  // output register
  logic [SAMPLE_W-1:0]        out_data;
  logic [CHW-1:0]             out_ch;

  // store port
  logic                       store_ready;
  logic                       st_we;
  logic                       st_re;
  logic [SAW-1:0]             st_addr;
  logic signed [CELL_W-1:0]   st_wdata;
  logic signed [CELL_W-1:0]   st_rdata;

  // divider
  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  logic [LW-1:0]              div_q;

  // combinational helpers
  logic                       accept;
  logic                       in_act;
  logic [CHW-1:0]             in_ch;
  logic                       ch_ok;
  logic [RW-1:0]              rp_cur;
  logic [RW-1:0]              rp_next;
  logic [RW-1:0]              erase_idx;
  logic [SAW-1:0]             base;
  logic [LW-1:0]              len_calc;
  logic signed [LW:0]         len_sum;
  logic [GW:0]                wp_sum;
  logic [RW-1:0]              wp_calc;
  logic signed [PW-1:0]       prod_calc;
  logic signed [PW:0]         far_sum;
  logic signed [SAMPLE_W:0]   far_calc;
  logic signed [SAMPLE_W:0]   add_op;
  logic signed [CELL_W-1:0]   cell_sum;
  logic [GW-1:0]              t_clamp;
  logic [LW-1:0]              t_len;
  logic signed [LW:0]         diff;
  logic [LW-1:0]              mag;
  logic                       out_free;

  assign in_act = s_tuser[0];
  assign in_ch = s_tuser[CHW:1];
  assign ch_ok = ({1'b0, in_ch} < (CHW + 1)'(NUM_CHANNELS));
  assign s_tready = (state == S_IDLE) && store_ready;
  assign accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;

  // read head and its neighbours
  assign rp_cur = rp[ch_r];
  assign rp_next = (rp_cur == RW'(MAX_DELAY - 1)) ? '0 : rp_cur + 1'b1;
  assign erase_idx = (rp_cur == '0) ? RW'(MAX_DELAY - 1) : rp_cur - 1'b1;
  assign base = SAW'(ch_r) * SAW'(MAX_DELAY);

  // length for this sample: one step of the glide
  assign len_sum = $signed({1'b0, cur_len[ch_r]}) + ramp_inc[ch_r];
  always_comb begin
    if (ramp_rem[ch_r] == '0) begin
      len_calc = cur_len[ch_r];
    end else if (ramp_rem[ch_r] == STEPS_W'(1)) begin
      len_calc = {goal[ch_r], {FRAC_BITS{1'b0}}};
    end else begin
      len_calc = len_sum[LW-1:0];
    end
  end

  // write head = read + floor(len), wrapped once
  assign wp_sum = (GW + 1)'(rp_cur) + (GW + 1)'(len_r[LW-1:FRAC_BITS]);
  assign wp_calc = (wp_sum >= (GW + 1)'(MAX_DELAY)) ? RW'(wp_sum - (GW + 1)'(MAX_DELAY))
                                                    : RW'(wp_sum);

  // far share: floor((x * frac + 2048) / 4096)
  assign prod_calc = x_r * $signed({1'b0, len_r[FRAC_BITS-1:0]});
  assign far_sum = (PW + 1)'(prod_r) + (PW + 1)'(HALF_LSB);
  assign far_calc = far_sum[FRAC_BITS +: (SAMPLE_W + 1)];

  // shared saturating cell adder
  assign add_op = (state == S_NEAR) ? near_r : far_r;
  assign cell_sum = sat_cell($signed({st_rdata[CELL_W-1], st_rdata})
                             + $signed({{(CELL_W - SAMPLE_W){add_op[SAMPLE_W]}}, add_op}));

  // target clamp and glide distance
  assign t_clamp = (TW'(tgt_r) > TW'(MAX_DELAY)) ? GW'(MAX_DELAY) : GW'(tgt_r);
  assign t_len = {t_clamp, {FRAC_BITS{1'b0}}};
  assign diff = $signed({1'b0, t_len}) - $signed({1'b0, cur_len[ch_r]});
  assign mag = diff[LW] ? LW'(-diff) : diff[LW-1:0];
  assign div_start = (state == S_SET) && (t_clamp != goal[ch_r]) && (ramp_steps != '0);

  // store access per step
  always_comb begin
    st_we = 1'b0;
    st_re = 1'b0;
    st_addr = base;
    st_wdata = cell_sum;
    unique case (state)
      S_ERASE: begin
        st_we = 1'b1;
        st_addr = base + SAW'(erase_idx);
        st_wdata = '0;
      end
      S_SPLIT: begin
        st_re = 1'b1;
        st_addr = base + SAW'(wp_r);
      end
      S_NEAR: begin
        st_we = 1'b1;
        st_addr = base + SAW'(wp_r);
      end
      S_FAR_RD: begin
        st_re = 1'b1;
        st_addr = base + SAW'(wp1_r);
      end
      S_FAR: begin
        st_we = 1'b1;
        st_addr = base + SAW'(wp1_r);
      end
      S_RD: begin
        st_re = 1'b1;
        st_addr = base + SAW'(rp_cur);
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && ch_ok) begin
            state <= (in_act == ACT_SET) ? S_SET : S_ERASE;
          end
        end
        S_ERASE:  state <= S_MUL;
        S_MUL:    state <= S_SPLIT;
        S_SPLIT:  state <= S_NEAR;
        S_NEAR:   state <= S_FAR_RD;
        S_FAR_RD: state <= S_FAR;
        S_FAR:    state <= S_RD;
        S_RD:     state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SET:    state <= div_start ? S_DIV : S_IDLE;
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // beat latch and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r <= in_ch;
      x_r <= $signed(s_tdata[SAMPLE_W-1:0]);
      tgt_r <= s_tdata[SAMPLE_W +: TARGET_W];
    end
    if (state == S_ERASE) begin
      len_r <= len_calc;
    end
    if (state == S_MUL) begin
      prod_r <= prod_calc;
      wp_r <= wp_calc;
    end
    if (state == S_SPLIT) begin
      far_r <= far_calc;
      near_r <= $signed({x_r[SAMPLE_W-1], x_r}) - far_calc;
      wp1_r <= (wp_r == RW'(MAX_DELAY - 1)) ? '0 : wp_r + 1'b1;
    end
    if (div_start) begin
      neg_r <= diff[LW];
    end
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rp[i] <= '0;
        cur_len[i] <= '0;
        goal[i] <= '0;
        ramp_inc[i] <= '0;
        ramp_rem[i] <= '0;
      end
    end else begin
      if (state == S_ERASE) begin
        cur_len[ch_r] <= len_calc;
        if (ramp_rem[ch_r] != '0) begin
          ramp_rem[ch_r] <= ramp_rem[ch_r] - 1'b1;
        end
      end
      if (state == S_OUT && out_free) begin
        rp[ch_r] <= rp_next;
      end
      if (state == S_SET && t_clamp != goal[ch_r]) begin
        goal[ch_r] <= t_clamp;
        if (ramp_steps == '0) begin
          cur_len[ch_r] <= t_len;
          ramp_rem[ch_r] <= '0;
          ramp_inc[ch_r] <= '0;
        end else begin
          ramp_rem[ch_r] <= ramp_steps;
        end
      end
      if (state == S_DIV && div_done) begin
        ramp_inc[ch_r] <= neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      end
    end
  end

  // ramp_steps register
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_steps <= RAMP_STEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      ramp_steps <= cfg_data;
    end
  end

  // output register: frees the sequencer once the slot is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_data <= sat_out(st_rdata);
      out_ch <= ch_r;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_ch;

  rfwdl_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ready (store_ready),
    .we    (st_we),
    .re    (st_re),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  rfwdl_div #(
    .DW(LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (ramp_steps),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // divider only runs while the sequencer waits on it
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV || state == S_SET))
    else $error("divider busy outside glide set-up");

  // sequencer never leaves idle before the clearing sweep is done
  a_run_after_clear: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> store_ready)
    else $error("sequencer active during store clear");

  // glide never leaves the store's range
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (len_r <= {GW'(MAX_DELAY), {FRAC_BITS{1'b0}}}))
    else $error("length beyond MAX_DELAY");

  // a finished sample beat lands in the output register with its channel
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (m_tvalid && m_tuser == $past(ch_r)))
    else $error("result not loaded");

endmodule

### rtl/rfwdl_div.sv
// Restoring divider for the glide step: one quotient bit per cycle.
// Uses rfwdl_pkg for the divisor width.
module rfwdl_div #(
  parameter int DW = 25,
  localparam int CNTW = $clog2(DW + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [rfwdl_pkg::STEPS_W-1:0] divisor,
  output logic                          busy,
  output logic                          done,
  output logic [DW-1:0]                 quotient
);
  import rfwdl_pkg::*;

  logic [CNTW-1:0]    cnt;
  logic [DW-1:0]      quo;
  logic [STEPS_W-1:0] rem;
  logic [STEPS_W-1:0] dvs;
  logic [STEPS_W:0]   shifted;
  logic [STEPS_W:0]   diff;

  assign shifted = {rem, quo[DW-1]};
  assign diff = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNTW'(DW);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy && cnt != '0) begin
      if (!diff[STEPS_W]) begin
        rem <= diff[STEPS_W-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= shifted[STEPS_W-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  assign done = busy && (cnt == '0);
  assign quotient = quo;

endmodule

### rtl/rfwdl_store.sv
// Single-port delay store with registered read data and a clearing sweep
// after reset. Uses rfwdl_pkg for the cell width.
module rfwdl_store #(
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  output logic                                ready,
  input  logic                                we,
  input  logic                                re,
  input  logic [AW-1:0]                       addr,
  input  logic signed [rfwdl_pkg::CELL_W-1:0] wdata,
  output logic signed [rfwdl_pkg::CELL_W-1:0] rdata
);
  import rfwdl_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic              clearing;
  logic [AW-1:0]     clr_addr;
  logic              wen;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign wen = clearing || we;
  assign waddr = clearing ? clr_addr : addr;
  assign wd = clearing ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wd;
    end
    if (re && !clearing) begin
      rdata <= mem[addr];
    end
  end

  assign ready = !clearing;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for ramped_fractional_write_delay_line: sample and set beats go in,
// every delayed sample is predicted here and compared with the result beats.
// Depends on rfwdl_pkg and the delay line rtl.
module testbench;
  import rfwdl_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int N_CH = 2;
  localparam int QUIET_LIMIT = 40000;  // allows for the clearing sweep after reset
  localparam int SETTLE_CYCLES = 48;   // allows for a set beat that starts a glide
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int RANDOM_ITEMS = 150;   // per idling mix
  localparam int REPORT_MAX = 10;
  localparam int CELL_HI = 131071;
  localparam int CELL_LO = -131072;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                ch;
  } delayed_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_IN_W-1:0] s_tdata = '0;   // sample_in, target_length, zero pad
  logic [1:0]            s_tuser = '0;   // action, channel
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;        // sample_out
  logic [0:0]            m_tuser;        // out_channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [STEPS_W-1:0]    cfg_data = '0;

  // idling mix, receiver hold-off request
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic hold_go = 1'b0;
  int   hold_left = 0;

  // run bookkeeping
  int beats_in = 0;
  int set_beats = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // predictor state: one tape per channel plus the glide of each channel
  logic signed [CELL_W-1:0] tape [N_CH][STORE_DEPTH];
  logic [11:0]              head_pos [N_CH];
  logic [23:0]              len_q12 [N_CH];     // Q12.12 length
  logic [12:0]              goal_len [N_CH];
  logic signed [25:0]       glide_inc [N_CH];   // Q13.12 step per sample
  logic [STEPS_W-1:0]       glide_left [N_CH];
  logic [STEPS_W-1:0]       glide_steps;
  delayed_t                 due_samples [$];

  always #5 clk = ~clk;

  ramped_fractional_write_delay_line #(
    .MAX_DELAY   (STORE_DEPTH),
    .NUM_CHANNELS(N_CH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // New target: clamp, drop a repeat of the current goal, else start a glide.
  // Step is truncated toward zero so the glide never overshoots.
  function automatic void start_glide(input int ch, input logic [TARGET_W-1:0] tgt);
    int t;
    int diff;
    int mag;
    t = (int'(tgt) > STORE_DEPTH) ? STORE_DEPTH : int'(tgt);
    if (t == int'(goal_len[ch])) return;   // glide in progress carries on
    goal_len[ch] = 13'(t);
    if (glide_steps == 0) begin
      len_q12[ch] = 24'(t << FRAC_BITS);
      glide_left[ch] = '0;
      glide_inc[ch] = '0;
      return;
    end
    diff = (t << FRAC_BITS) - int'(len_q12[ch]);
    mag = (diff < 0 ? -diff : diff) / int'(glide_steps);
    glide_inc[ch] = 26'((diff < 0) ? -mag : mag);
    glide_left[ch] = glide_steps;
  endfunction

  // One sample's worth of glide; the last step lands exactly on the goal.
  function automatic logic [23:0] glide_tick(input int ch);
    int acc;
    if (glide_left[ch] != 0) begin
      glide_left[ch]--;
      if (glide_left[ch] == 0) begin
        len_q12[ch] = 24'(goal_len[ch]) << FRAC_BITS;
      end else begin
        acc = int'(len_q12[ch]) + int'(glide_inc[ch]);
        len_q12[ch] = acc[23:0];
      end
    end
    return len_q12[ch];
  endfunction

  function automatic void tape_add(input int ch, input logic [11:0] idx, input int v);
    int s;
    s = int'(tape[ch][idx]) + v;
    if (s > CELL_HI) s = CELL_HI;
    else if (s < CELL_LO) s = CELL_LO;
    tape[ch][idx] = s[CELL_W-1:0];
  endfunction

  // Works out what one accepted beat does; a sample beat queues its delayed sample.
  function automatic void predict_delay_step(input logic act, input logic ch_bit,
                                             input logic signed [SAMPLE_W-1:0] x,
                                             input logic [TARGET_W-1:0] tgt);
    int          ch;
    int          xs;
    int          fr;
    int          far_share;
    int          y;
    logic [11:0] rp;
    logic [11:0] wp;
    logic [23:0] len;
    delayed_t    d;
    ch = int'(ch_bit);
    if (act == ACT_SET) begin
      start_glide(ch, tgt);
      return;
    end
    xs = int'(x);
    rp = head_pos[ch];
    tape[ch][rp - 12'd1] = '0;              // erase just behind the read head
    len = glide_tick(ch);
    fr = int'(len[11:0]);
    far_share = (xs * fr + HALF_LSB) >>> FRAC_BITS;
    wp = rp + len[23:12];                   // wraps at the store depth
    tape_add(ch, wp, xs - far_share);
    tape_add(ch, wp + 12'd1, far_share);
    y = int'(tape[ch][rp]);
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    head_pos[ch] = rp + 12'd1;
    d.sample = y[SAMPLE_W-1:0];
    d.ch = ch_bit;
    due_samples.push_back(d);
  endfunction

  function automatic void log_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch at %0t: %s", $time, what);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: results are checked before new beats are predicted, all in one
  // process so the order within an edge is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    delayed_t want;
    int       i;
    int       j;
    if (rst) begin
      for (i = 0; i < N_CH; i++) begin
        for (j = 0; j < STORE_DEPTH; j++) tape[i][j] = '0;
        head_pos[i] = '0;
        len_q12[i] = '0;
        goal_len[i] = '0;
        glide_inc[i] = '0;
        glide_left[i] = '0;
      end
      glide_steps = RAMP_STEPS_RST;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_samples.size() == 0) begin
          log_mismatch($sformatf("result beat with nothing due: sample %h ch %0d",
                                 m_tdata, m_tuser));
        end else begin
          want = due_samples.pop_front();
          if (m_tdata !== want.sample)
            log_mismatch($sformatf("ch %0d sample_out: expected %h, got %h",
                                   want.ch, want.sample, m_tdata));
          if (m_tuser[0] !== want.ch)
            log_mismatch($sformatf("out_channel: expected %0d, got %0d", want.ch, m_tuser));
        end
      end
      if (cfg_valid && cfg_ready) glide_steps = cfg_data;
      if (s_tvalid && s_tready) begin
        beats_in++;
        if (s_tuser[0] == ACT_SET) set_beats++;
        predict_delay_step(s_tuser[0], s_tuser[1], s_tdata[SAMPLE_W-1:0],
                           s_tdata[SAMPLE_W +: TARGET_W]);
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // Receiver: random stalls, or a counted hold-off once asked for.
  always @(posedge clk) begin
    if (hold_go) hold_left = HOLD_CYCLES;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on beats of any kind.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. push_beat returns at the edge its beat is taken; valid stays up, so
  // the caller either offers the next beat or goes idle in that same step.
  // ---------------------------------------------------------------------------
  task automatic push_beat(input logic act, input logic ch,
                           input logic [SAMPLE_W-1:0] x, input logic [TARGET_W-1:0] tgt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(TDATA_IN_W - SAMPLE_W - TARGET_W){1'b0}}, tgt, x};
    s_tuser <= {ch, act};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic push_random_item();
    logic                act;
    logic                ch;
    logic [SAMPLE_W-1:0] x;
    logic [TARGET_W-1:0] tgt;
    int                  pick;
    act = ($urandom_range(99) < 15) ? ACT_SET : ACT_SAMPLE;
    ch = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 50) x = 16'($urandom);
    else if (pick < 70) x = pick[0] ? 16'h7fff : 16'h8000;
    else x = 16'($urandom_range(512) - 256);
    // mostly short lengths so that written samples come back round soon
    pick = $urandom_range(99);
    if (pick < 60) tgt = 12'($urandom_range(24));
    else if (pick < 90) tgt = 12'($urandom_range(200));
    else tgt = 12'($urandom);
    push_beat(act, ch, x, tgt);
  endtask

  // Idle the input, wait for every due sample, then allow for a set beat still
  // busy in the divider.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_steps(input logic [STEPS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, a repeated goal, a long glide and a retarget mid-glide,
  // all at the reset ramp length.
  task automatic test_directed_edges();
    push_beat(ACT_SAMPLE, 1'b0, 16'h7fff, 12'h000);
    push_beat(ACT_SAMPLE, 1'b0, 16'h8000, 12'hfff);
    push_beat(ACT_SAMPLE, 1'b0, 16'h0000, 12'h000);
    push_beat(ACT_SAMPLE, 1'b0, 16'hffff, 12'h000);
    push_beat(ACT_SAMPLE, 1'b0, 16'h5555, 12'h000);
    push_beat(ACT_SAMPLE, 1'b0, 16'haaaa, 12'h000);
    push_beat(ACT_SET,    1'b0, 16'h0000, 12'h000);   // same goal: ignored
    push_beat(ACT_SET,    1'b1, 16'h0000, 12'hfff);   // longest target, slow glide
    push_beat(ACT_SAMPLE, 1'b1, 16'h7fff, 12'h000);
    push_beat(ACT_SAMPLE, 1'b1, 16'h8000, 12'h000);
    push_beat(ACT_SAMPLE, 1'b1, 16'h1234, 12'h000);
    push_beat(ACT_SET,    1'b0, 16'hffff, 12'haaa);
    push_beat(ACT_SAMPLE, 1'b0, 16'h4000, 12'h000);
    push_beat(ACT_SET,    1'b0, 16'h0000, 12'h555);   // retarget mid-glide
    push_beat(ACT_SAMPLE, 1'b0, 16'hc000, 12'h000);
    push_beat(ACT_SAMPLE, 1'b0, 16'h0001, 12'h000);
    push_beat(ACT_SET,    1'b1, 16'h0000, 12'hfff);   // same goal, glide carries on
    push_beat(ACT_SAMPLE, 1'b1, 16'h7ffe, 12'h000);
    push_beat(ACT_SAMPLE, 1'b1, 16'h8001, 12'h000);
    settle();
  endtask

  // Jump at zero steps, glide at the longest ramp, register write mid-glide.
  task automatic test_step_register();
    int k;
    write_steps(16'd0);
    push_beat(ACT_SET, 1'b0, 16'h0000, 12'd2);
    for (k = 0; k < 4; k++) push_beat(ACT_SAMPLE, 1'b0, 16'(100 * (k + 1)), 12'h000);
    push_beat(ACT_SET, 1'b0, 16'h0000, 12'd2);
    settle();
    write_steps(16'hffff);
    push_beat(ACT_SET, 1'b0, 16'h0000, 12'd7);
    push_beat(ACT_SAMPLE, 1'b0, 16'h2000, 12'h000);
    settle();
    write_steps(16'd3);                               // glide on ch0 keeps its step
    for (k = 0; k < 3; k++) push_beat(ACT_SAMPLE, 1'b0, 16'h0800, 12'h000);
    push_beat(ACT_SET, 1'b0, 16'h0000, 12'd1);
    push_beat(ACT_SET, 1'b1, 16'h0000, 12'd0);
    for (k = 0; k < 4; k++) push_beat(ACT_SAMPLE, k[0], 16'hf000, 12'h000);
    settle();
  endtask

  // A glide shrinking by one sample per sample holds the write cell still, so
  // full-scale input piles up and saturates the cell and then the output.
  task automatic test_cell_saturation();
    int k;
    write_steps(16'd0);
    push_beat(ACT_SET, 1'b1, 16'h0000, 12'd48);
    push_beat(ACT_SET, 1'b0, 16'h0000, 12'd48);
    settle();
    write_steps(16'd48);
    push_beat(ACT_SET, 1'b1, 16'h0000, 12'd0);
    push_beat(ACT_SET, 1'b0, 16'h0000, 12'd0);
    for (k = 0; k < 60; k++) begin
      push_beat(ACT_SAMPLE, 1'b1, 16'h7fff, 12'h000);
      push_beat(ACT_SAMPLE, 1'b0, 16'h8000, 12'h000);
    end
    settle();
  endtask

  // Receiver holds off while the sender keeps offering, filling the block.
  task automatic test_output_backpressure();
    int k;
    write_steps(16'd4);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (k = 0; k < 40; k++) push_random_item();
    settle();
  endtask

  // Short bursts, each followed by a pause until nothing is due.
  task automatic test_paused_bursts();
    int b;
    int k;
    for (b = 0; b < 8; b++) begin
      for (k = 0; k < 5; k++) push_random_item();
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (due_samples.size() != 0) @(posedge clk);
    end
    settle();
  endtask

  // Four idling mixes, each with its own ramp length, extremes included.
  task automatic test_random_traffic();
    int phase;
    int k;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_steps(16'd0);                 src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin
          write_steps(16'($urandom_range(1, 24)));
          src_idle_pct = 88;
          sink_stall_pct = 0;
        end
        2: begin write_steps(16'hffff);              src_idle_pct = 0;  sink_stall_pct = 88; end
        default: begin
          write_steps(16'($urandom_range(1, 6)));
          src_idle_pct = 8;
          sink_stall_pct = 8;
        end
      endcase
      for (k = 0; k < RANDOM_ITEMS; k++) push_random_item();
      settle();
    end
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_step_register();
    test_cell_saturation();
    test_output_backpressure();
    test_paused_bursts();
    test_random_traffic();
    settle();
    $display("run: %0d beats in (%0d set beats), %0d delayed samples checked, %0d mismatches",
             beats_in, set_beats, results_seen, mismatches);
    $display("run: ramp lengths 0 to 65535, saturating glides, hold-off and four idling mixes");
    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### ramped_fractional_write_delay_line.f
rtl/rfwdl_pkg.sv
rtl/rfwdl_div.sv
rtl/rfwdl_store.sv
rtl/ramped_fractional_write_delay_line.sv
bench/testbench.sv
